// ----- rtl/core/kare_pkg.sv -----
// ---------------------------------------------------------------------------
// kare_pkg
// Shared types and constants of the key auto-repeat engine.
// ---------------------------------------------------------------------------
package kare_pkg;

	localparam int NUM_KEYS_DEF  = 16;
	localparam int MAX_RESULTS   = 16;
	localparam int CNT_W         = 5;
	localparam int QUEUE_DEPTH   = 2;
	localparam int TIME_W        = 64;
	localparam int DATA_W        = 32;
	localparam int PADDR_W       = 4;

	localparam logic [31:0] INITIAL_DELAY_RST   = 32'd400000;
	localparam logic [31:0] REPEAT_INTERVAL_RST = 32'd100000;
	localparam logic [15:0] REPEAT_MASK_RST     = 16'd15;

	// command codes of an input item; the fourth code is ignored
	typedef enum logic [1:0] {
		CMD_PRESS   = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_TICK    = 2'd2
	} kare_cmd_code_t;

	// configuration register indexes (byte address = 4 * index)
	typedef enum logic [1:0] {
		REG_INITIAL_DELAY   = 2'd0,
		REG_REPEAT_INTERVAL = 2'd1,
		REG_REPEAT_MASK     = 2'd2
	} kare_reg_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_FLUSH
	} kare_bk_state_t;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [3:0]        key_id;
		logic [1:0]        device;
		logic [3:0]        action;
		logic [TIME_W-1:0] timestamp;
	} kare_in_t;

	typedef struct packed {
		logic [TIME_W-1:0] event_time;
		logic [1:0]        event_device;
		logic [3:0]        event_action;
		logic              is_repeat;
		logic              last;
	} kare_out_t;

	// classified command handed from front to back
	typedef struct packed {
		kare_cmd_code_t    op;
		logic              key_ok;
		logic              arm;
		logic [3:0]        key_id;
		logic [1:0]        device;
		logic [3:0]        action;
		logic [TIME_W-1:0] now;
		logic [TIME_W-1:0] new_time;
	} kare_cmd_t;

	// one slot of the repeat table
	typedef struct packed {
		logic [1:0]        device;
		logic [3:0]        action;
		logic [TIME_W-1:0] next_time;
	} kare_slot_t;

endpackage

// ----- rtl/core/kare_ram.sv -----
// ---------------------------------------------------------------------------
// kare_ram
// Generic one-write one-read RAM with registered read data.
// ---------------------------------------------------------------------------
module kare_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port, read port with held data while re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/core/kare_fifo.sv -----
// ---------------------------------------------------------------------------
// kare_fifo
// Small register queue; used between front and back and at the result side.
// ---------------------------------------------------------------------------
module kare_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CntW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// store the pushed item
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end

endmodule

// ----- rtl/core/kare_front.sv -----
// ---------------------------------------------------------------------------
// kare_front
// Configuration registers, input classification and schedule-time adder.
// ---------------------------------------------------------------------------
module kare_front
	import kare_pkg::*;
#(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               push,
	input  kare_in_t           key_item,
	output logic               full,
	input  logic               cq_full,
	output logic               cq_push,
	output kare_cmd_t          cq_entry
);

	logic [31:0]       initial_delay_q;
	logic [31:0]       repeat_interval_q;
	logic [15:0]       repeat_mask_q;
	logic [1:0]        reg_idx;
	logic              cfg_wr;
	logic [31:0]       add_inc;
	logic [TIME_W:0]   add_sum;
	logic              is_cmd;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_delay_q   <= INITIAL_DELAY_RST;
			repeat_interval_q <= REPEAT_INTERVAL_RST;
			repeat_mask_q     <= REPEAT_MASK_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_INITIAL_DELAY:   initial_delay_q   <= pwdata;
				REG_REPEAT_INTERVAL: repeat_interval_q <= pwdata;
				REG_REPEAT_MASK:     repeat_mask_q     <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back configuration registers
	always_comb begin
		case (reg_idx)
			REG_INITIAL_DELAY:   prdata = initial_delay_q;
			REG_REPEAT_INTERVAL: prdata = repeat_interval_q;
			REG_REPEAT_MASK:     prdata = {16'd0, repeat_mask_q};
			default:             prdata = '0;
		endcase
	end

	// saturating add of delay or interval to the timestamp
	assign add_inc = (key_item.cmd == CMD_TICK) ? repeat_interval_q : initial_delay_q;
	assign add_sum = {1'b0, key_item.timestamp} + (TIME_W + 1)'(add_inc);

	// classify the item; drop the unused command code
	assign is_cmd = (key_item.cmd == CMD_PRESS) || (key_item.cmd == CMD_RELEASE) ||
	                (key_item.cmd == CMD_TICK);
	assign full    = cq_full;
	assign cq_push = push && !cq_full && is_cmd;

	always_comb begin
		cq_entry.op       = kare_cmd_code_t'(key_item.cmd);
		cq_entry.key_ok   = (int'(key_item.key_id) < NUM_KEYS);
		cq_entry.arm      = repeat_mask_q[key_item.action];
		cq_entry.key_id   = key_item.key_id;
		cq_entry.device   = key_item.device;
		cq_entry.action   = key_item.action;
		cq_entry.now      = key_item.timestamp;
		cq_entry.new_time = add_sum[TIME_W] ? '1 : add_sum[TIME_W-1:0];
	end

endmodule

// ----- rtl/core/kare_back.sv -----
// ---------------------------------------------------------------------------
// kare_back
// Slot table and sequencer: applies presses and releases, scans on a tick.
// ---------------------------------------------------------------------------
module kare_back
	import kare_pkg::*;
#(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cq_valid,
	input  kare_cmd_t cq_entry,
	output logic      cq_pop,
	input  logic      oq_full,
	output logic      oq_push,
	output kare_out_t oq_item
);

	localparam int IdxW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	kare_bk_state_t   state_q;
	kare_bk_state_t   state_d;
	logic             armed_q [NUM_KEYS];
	logic [IdxW:0]    rd_idx_q;
	logic             s1_vld_q;
	logic [IdxW-1:0]  s1_idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             hold_vld_q;
	kare_out_t        hold_q;
	logic [TIME_W-1:0] tick_now_q;
	logic [TIME_W-1:0] tick_next_q;

	kare_slot_t       rd_slot;
	kare_slot_t       wr_slot;
	logic             ram_we;
	logic [IdxW-1:0]  ram_waddr;
	logic             ram_re;
	logic             scan_go;
	logic             rd_more;
	logic             slot_due;
	logic             due_fire;
	logic             scan_done;
	logic             idle_take;
	logic [IdxW-1:0]  key_addr;
	kare_out_t        due_item;

	kare_ram #(
		.WIDTH($bits(kare_slot_t)),
		.DEPTH(NUM_KEYS)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(wr_slot),
		.re   (ram_re),
		.raddr(rd_idx_q[IdxW-1:0]),
		.rdata(rd_slot)
	);

	// scan control: one slot read per cycle while the result queue has room, each checked from registered data
	assign key_addr  = IdxW'(cq_entry.key_id);
	assign scan_go   = (state_q == BK_SCAN) && !oq_full;
	assign rd_more   = (rd_idx_q < (IdxW + 1)'(NUM_KEYS));
	assign ram_re    = scan_go && rd_more;
	assign slot_due  = s1_vld_q && armed_q[s1_idx_q] && (rd_slot.next_time <= tick_now_q) &&
	                   (cnt_q < CNT_W'(MAX_RESULTS));
	assign due_fire  = scan_go && slot_due;
	assign scan_done = scan_go && !rd_more && !s1_vld_q;
	assign idle_take = (state_q == BK_IDLE) && cq_valid &&
	                   ((cq_entry.op != CMD_PRESS) || !oq_full);

	always_comb begin
		due_item.event_time   = rd_slot.next_time;
		due_item.event_device = rd_slot.device;
		due_item.event_action = rd_slot.action;
		due_item.is_repeat    = 1'b1;
		due_item.last         = 1'b0;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (idle_take && (cq_entry.op == CMD_TICK)) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (scan_done) begin
					state_d = BK_FLUSH;
				end
			end
			BK_FLUSH: begin
				if (!hold_vld_q || !oq_full) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs: queue pop, table writes, result pushes
	always_comb begin
		cq_pop    = 1'b0;
		oq_push   = 1'b0;
		oq_item   = hold_q;
		ram_we    = 1'b0;
		ram_waddr = s1_idx_q;
		wr_slot   = rd_slot;
		case (state_q)
			BK_IDLE: begin
				cq_pop = idle_take;
				if (idle_take && (cq_entry.op == CMD_PRESS)) begin
					oq_push              = 1'b1;
					oq_item.event_time   = cq_entry.now;
					oq_item.event_device = cq_entry.device;
					oq_item.event_action = cq_entry.action;
					oq_item.is_repeat    = 1'b0;
					oq_item.last         = 1'b1;
					ram_we               = cq_entry.key_ok && cq_entry.arm;
					ram_waddr            = key_addr;
					wr_slot.device       = cq_entry.device;
					wr_slot.action       = cq_entry.action;
					wr_slot.next_time    = cq_entry.new_time;
				end
			end
			BK_SCAN: begin
				if (due_fire) begin
					ram_we            = 1'b1;
					wr_slot.next_time = tick_next_q;
					oq_push           = hold_vld_q;
					oq_item.last      = 1'b0;
				end
			end
			BK_FLUSH: begin
				oq_push      = hold_vld_q && !oq_full;
				oq_item.last = 1'b1;
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_IDLE;
			rd_idx_q   <= '0;
			s1_vld_q   <= 1'b0;
			cnt_q      <= '0;
			hold_vld_q <= 1'b0;
			for (int i = 0; i < NUM_KEYS; i++) begin
				armed_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			if (idle_take) begin
				case (cq_entry.op)
					CMD_PRESS: begin
						if (cq_entry.key_ok) begin
							armed_q[key_addr] <= cq_entry.arm;
						end
					end
					CMD_RELEASE: begin
						if (cq_entry.key_ok) begin
							armed_q[key_addr] <= 1'b0;
						end
					end
					CMD_TICK: begin
						rd_idx_q   <= '0;
						s1_vld_q   <= 1'b0;
						cnt_q      <= '0;
						hold_vld_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (scan_go) begin
				s1_vld_q <= rd_more;
				if (rd_more) begin
					rd_idx_q <= rd_idx_q + (IdxW + 1)'(1);
				end
			end
			if (due_fire) begin
				hold_vld_q <= 1'b1;
				cnt_q      <= cnt_q + CNT_W'(1);
			end
			if ((state_q == BK_FLUSH) && !oq_full) begin
				hold_vld_q <= 1'b0;
			end
		end
	end

	// payload registers of the scan
	always_ff @(posedge clk) begin
		if (idle_take && (cq_entry.op == CMD_TICK)) begin
			tick_now_q  <= cq_entry.now;
			tick_next_q <= cq_entry.new_time;
		end
		if (scan_go) begin
			s1_idx_q <= rd_idx_q[IdxW-1:0];
		end
		if (due_fire) begin
			hold_q <= due_item;
		end
	end

	// a result is never pushed into a full result queue
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		oq_push |-> !oq_full)
		else $error("result pushed while queue full");

	// a slot update never collides with the slot being read
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != rd_idx_q[IdxW-1:0]))
		else $error("slot write and read at the same address");

	// never more repeats per tick than allowed
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("repeat count exceeds limit");

	// a held repeat is always flushed before the next command is taken
	a_hold_empty_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_IDLE) |-> !hold_vld_q)
		else $error("held repeat left behind in idle");

	// a tick scan always ends in the flush state
	a_scan_to_flush: assert property (@(posedge clk) disable iff (!arst_n)
		scan_done |=> (state_q == BK_FLUSH))
		else $error("scan did not end in flush");

endmodule

// ----- rtl/core/key_auto_repeat_engine.sv -----
// ---------------------------------------------------------------------------
// key_auto_repeat_engine
// Typematic auto-repeat table with one slot per key; emits press and repeat
// events.
// ---------------------------------------------------------------------------
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------
//   input    | push / full        | key_item   (cmd, key, device, action, time)
//   result   | pop / empty        | event_item (time, device, action, flags)
//   config   | psel/penable/pready| paddr, pwdata, prdata
//
// A press or release is taken from the command queue in the idle state; a press
// emits one event. A tick is taken in idle; the scan then issues one slot read
// per cycle while the result queue has room, checks each slot from the registered
// read data and closes, and the flush state pushes the last held repeat. Reset
// clears the armed flags at once; no clearing pass is needed. A full result queue
// stalls the back end; a two-entry command queue keeps accepting items until full.
// ---------------------------------------------------------------------------
module key_auto_repeat_engine
	import kare_pkg::*;
#(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               push,
	output logic               full,
	input  kare_in_t           key_item,
	input  logic               pop,
	output logic               empty,
	output kare_out_t          event_item
);

	logic      cq_full;
	logic      cq_push;
	kare_cmd_t cq_wentry;
	kare_cmd_t cq_rentry;
	logic      cq_empty;
	logic      cq_pop;
	logic      oq_full;
	logic      oq_push;
	kare_out_t oq_item;

	kare_front #(
		.NUM_KEYS(NUM_KEYS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.push    (push),
		.key_item(key_item),
		.full    (full),
		.cq_full (cq_full),
		.cq_push (cq_push),
		.cq_entry(cq_wentry)
	);

	// command queue between front and back
	kare_fifo #(
		.WIDTH($bits(kare_cmd_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cq_push),
		.wdata (cq_wentry),
		.full  (cq_full),
		.pop   (cq_pop),
		.rdata (cq_rentry),
		.empty (cq_empty)
	);

	kare_back #(
		.NUM_KEYS(NUM_KEYS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cq_valid(!cq_empty),
		.cq_entry(cq_rentry),
		.cq_pop  (cq_pop),
		.oq_full (oq_full),
		.oq_push (oq_push),
		.oq_item (oq_item)
	);

	// result queue toward the consumer
	kare_fifo #(
		.WIDTH($bits(kare_out_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_evt_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (oq_push),
		.wdata (oq_item),
		.full  (oq_full),
		.pop   (pop),
		.rdata (event_item),
		.empty (empty)
	);

endmodule
